>>> rtl/utcdn_pkg.sv
// ----------------------------------------------------------------------------
// utcdn_pkg
// Shared constants and helpers for the UTC date/time normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package utcdn_pkg;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam int MIN_PER_DAY = 1440;

	// Reciprocals for division by a constant: floor(x * R >> S) == floor(x / D)
	// over the value ranges used here.
	localparam int unsigned RECIP25 = 41944; // ceil(2^20 / 25), year < 2^14
	localparam int unsigned RECIP25_SHIFT = 20;
	localparam int unsigned RECIP60 = 1093;  // ceil(2^16 / 60), minute of day < 1440
	localparam int unsigned RECIP60_SHIFT = 16;

	typedef logic [13:0] year_t;
	typedef logic [6:0] field_t;
	typedef logic signed [11:0] zone_t;
	typedef logic signed [14:0] utc_year_t;

	// Gregorian month length; month codes outside 1..12 are filtered elsewhere.
	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

>>> rtl/utcdn_in_if.sv
// ----------------------------------------------------------------------------
// utcdn_in_if
// Local date/time channel: valid/ready with the parsed fields and zone offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface utcdn_in_if;
	logic valid;
	logic ready;
	utcdn_pkg::year_t local_year;
	utcdn_pkg::field_t local_month;
	utcdn_pkg::field_t local_day;
	utcdn_pkg::field_t local_hour;
	utcdn_pkg::field_t local_minute;
	utcdn_pkg::field_t local_second;
	utcdn_pkg::zone_t zone_minutes;

	modport source (
		output valid, local_year, local_month, local_day, local_hour,
		       local_minute, local_second, zone_minutes,
		input  ready
	);

	modport sink (
		input  valid, local_year, local_month, local_day, local_hour,
		       local_minute, local_second, zone_minutes,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/utcdn_out_if.sv
// ----------------------------------------------------------------------------
// utcdn_out_if
// UTC date/time channel: valid/ready with the validity flag and UTC fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface utcdn_out_if;
	logic valid;
	logic ready;
	logic date_valid;
	utcdn_pkg::utc_year_t utc_year;
	logic [3:0] utc_month;
	logic [4:0] utc_day;
	logic [4:0] utc_hour;
	logic [5:0] utc_minute;
	logic [5:0] utc_second;

	modport source (
		output valid, date_valid, utc_year, utc_month, utc_day, utc_hour,
		       utc_minute, utc_second,
		input  ready
	);

	modport sink (
		input  valid, date_valid, utc_year, utc_month, utc_day, utc_hour,
		       utc_minute, utc_second,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/utc_datetime_normalizer_unit.sv
// ----------------------------------------------------------------------------
// utc_datetime_normalizer_unit
// Checks a parsed local date/time and converts it to UTC using a zone offset.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. Each beat is captured in an input
// register and the checked, converted result lands in an output register. A
// new beat is taken every cycle as long as the block does not stall; the only
// stall is a result held on rsp by a low rsp.ready with the
// input register also full. Invalid dates (month outside 1..12, day beyond the
// Gregorian month length, hour above 23, minute or second above 59) give
// date_valid low and all fields zero. The offset moves the date by at most two
// days, applied as a direct calendar step; years run from -1 up, and a result
// year outside 15 signed bits keeps its low bits. No reset sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_datetime_normalizer_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	utcdn_in_if.sink   req,
	utcdn_out_if.source rsp
);

	// Input register
	logic valid_s1;
	utcdn_pkg::year_t year_s1;
	utcdn_pkg::field_t month_s1;
	utcdn_pkg::field_t day_s1;
	utcdn_pkg::field_t hour_s1;
	utcdn_pkg::field_t minute_s1;
	utcdn_pkg::field_t second_s1;
	utcdn_pkg::zone_t zone_s1;

	// Result register
	logic valid_s2;
	logic date_valid_s2;
	utcdn_pkg::utc_year_t year_s2;
	logic [3:0] month_s2;
	logic [4:0] day_s2;
	logic [4:0] hour_s2;
	logic [5:0] minute_s2;
	logic [5:0] second_s2;

	logic advance;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			year_s1   <= req.local_year;
			month_s1  <= req.local_month;
			day_s1    <= req.local_day;
			hour_s1   <= req.local_hour;
			minute_s1 <= req.local_minute;
			second_s1 <= req.local_second;
			zone_s1   <= req.zone_minutes;
		end
	end

	// ---------------- field check ----------------
	logic month_ok;
	logic [3:0] month4;
	logic [30:0] prod25;
	logic [9:0] q25;
	logic [13:0] q25x25;
	logic div25;
	logic leap;
	logic [4:0] mlen;
	logic day_ok;
	logic fields_ok;

	assign month_ok = (month_s1 >= 7'd1) && (month_s1 <= 7'(utcdn_pkg::MONTH_DEC));
	assign month4   = month_s1[3:0];

	// year % 25 == 0 via reciprocal quotient and back-multiply
	assign prod25 = 31'(year_s1) * 31'(utcdn_pkg::RECIP25);
	assign q25    = prod25[utcdn_pkg::RECIP25_SHIFT +: 10];
	assign q25x25 = 14'({q25, 4'b0}) + 14'({q25, 3'b0}) + 14'(q25);
	assign div25  = (q25x25 == year_s1);
	assign leap   = (year_s1[1:0] == 2'd0) && (!div25 || (year_s1[3:0] == 4'd0));

	assign mlen      = utcdn_pkg::days_in_month(month4, leap);
	assign day_ok    = (day_s1 >= 7'd1) && (day_s1 <= 7'(mlen));
	assign fields_ok = month_ok && day_ok && (hour_s1 <= 7'd23) &&
	                   (minute_s1 <= 7'd59) && (second_s1 <= 7'd59);

	// ---------------- time of day ----------------
	localparam logic signed [13:0] DAY_M = 14'(utcdn_pkg::MIN_PER_DAY);

	logic [12:0] tod;
	logic signed [13:0] tmin;
	logic signed [2:0] day_step;
	logic signed [13:0] tmin_norm;
	logic [10:0] tm;
	logic [21:0] prod60;
	logic [4:0] hr;
	logic [10:0] mn;

	assign tod  = 13'({hour_s1, 6'b0}) - 13'({hour_s1, 2'b0}) + 13'(minute_s1);
	assign tmin = $signed({1'b0, tod}) - 14'(zone_s1);

	always_comb begin
		if (tmin < -DAY_M) begin
			day_step  = -3'sd2;
			tmin_norm = tmin + DAY_M + DAY_M;
		end else if (tmin < 14'sd0) begin
			day_step  = -3'sd1;
			tmin_norm = tmin + DAY_M;
		end else if (tmin < DAY_M) begin
			day_step  = 3'sd0;
			tmin_norm = tmin;
		end else if (tmin < DAY_M + DAY_M) begin
			day_step  = 3'sd1;
			tmin_norm = tmin - DAY_M;
		end else begin
			day_step  = 3'sd2;
			tmin_norm = tmin - DAY_M - DAY_M;
		end
	end

	assign tm     = tmin_norm[10:0];
	assign prod60 = 22'(tm) * 22'(utcdn_pkg::RECIP60);
	assign hr     = prod60[utcdn_pkg::RECIP60_SHIFT +: 5];
	// minute = tm - 60 * hr
	assign mn     = tm - 11'({hr, 6'b0}) + 11'({hr, 2'b0});

	// ---------------- calendar step ----------------
	logic signed [8:0] dsum;
	logic [3:0] prev_month;
	logic [4:0] prev_len;
	logic [8:0] new_day;
	logic [3:0] new_month;
	logic signed [1:0] year_step;
	utcdn_pkg::utc_year_t new_year;

	assign dsum       = $signed({2'b0, day_s1}) + 9'(day_step);
	assign prev_month = (month4 == utcdn_pkg::MONTH_JAN) ? utcdn_pkg::MONTH_DEC : month4 - 4'd1;
	assign prev_len   = utcdn_pkg::days_in_month(prev_month, leap);

	always_comb begin
		new_day   = 9'(dsum);
		new_month = month4;
		year_step = 2'sd0;
		if (dsum > $signed({4'b0, mlen})) begin
			// roll into next month
			new_day = 9'(dsum - $signed({4'b0, mlen}));
			if (month4 == utcdn_pkg::MONTH_DEC) begin
				new_month = utcdn_pkg::MONTH_JAN;
				year_step = 2'sd1;
			end else begin
				new_month = month4 + 4'd1;
			end
		end else if (dsum < 9'sd1) begin
			// borrow from previous month
			new_day   = 9'(dsum + $signed({4'b0, prev_len}));
			new_month = prev_month;
			if (month4 == utcdn_pkg::MONTH_JAN) begin
				year_step = -2'sd1;
			end
		end
	end

	assign new_year = $signed({1'b0, year_s1}) + 15'(year_step);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			date_valid_s2 <= fields_ok;
			if (fields_ok) begin
				year_s2   <= new_year;
				month_s2  <= new_month;
				day_s2    <= new_day[4:0];
				hour_s2   <= hr;
				minute_s2 <= mn[5:0];
				second_s2 <= second_s1[5:0];
			end else begin
				year_s2   <= '0;
				month_s2  <= '0;
				day_s2    <= '0;
				hour_s2   <= '0;
				minute_s2 <= '0;
				second_s2 <= '0;
			end
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.date_valid = date_valid_s2;
	assign rsp.utc_year   = year_s2;
	assign rsp.utc_month  = month_s2;
	assign rsp.utc_day    = day_s2;
	assign rsp.utc_hour   = hour_s2;
	assign rsp.utc_minute = minute_s2;
	assign rsp.utc_second = second_s2;

endmodule

`default_nettype wire

>>> rtl/utcdn_checker.sv
// ----------------------------------------------------------------------------
// utcdn_checker
// Port-level checks for the UTC date/time normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utcdn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        date_valid,
	input wire logic [14:0] utc_year,
	input wire logic [3:0]  utc_month,
	input wire logic [4:0]  utc_day,
	input wire logic [4:0]  utc_hour,
	input wire logic [5:0]  utc_minute,
	input wire logic [5:0]  utc_second
);

	// An invalid beat carries all-zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !date_valid |->
			utc_year == 15'd0 && utc_month == 4'd0 && utc_day == 5'd0 &&
			utc_hour == 5'd0 && utc_minute == 6'd0 && utc_second == 6'd0)
		else $error("invalid result beat with nonzero fields");

	// A valid beat has date and time fields within their civil ranges.
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && date_valid |->
			utc_month >= 4'd1 && utc_month <= 4'd12 &&
			utc_day >= 5'd1 && utc_day <= 5'd31 &&
			utc_hour <= 5'd23 && utc_minute <= 6'd59 && utc_second <= 6'd59)
		else $error("valid result beat out of range");

	// Input stalls only when a result is waiting downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled without output backpressure");

	// A held result beat keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(date_valid) &&
			$stable(utc_year) && $stable(utc_month) && $stable(utc_day) &&
			$stable(utc_hour) && $stable(utc_minute) && $stable(utc_second))
		else $error("result beat changed while stalled");

endmodule

bind utc_datetime_normalizer_unit utcdn_checker u_utcdn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.date_valid (rsp.date_valid),
	.utc_year   (rsp.utc_year),
	.utc_month  (rsp.utc_month),
	.utc_day    (rsp.utc_day),
	.utc_hour   (rsp.utc_hour),
	.utc_minute (rsp.utc_minute),
	.utc_second (rsp.utc_second)
);

`default_nettype wire

>>> tb/tb_utc_datetime_normalizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utc_datetime_normalizer_unit
// Self-checking bench for the local-to-UTC date/time normalizer.
// ----------------------------------------------------------------------------
// A scoreboard predicts the UTC result of every accepted local beat by
// converting the date to a day count, applying the zone offset in seconds,
// splitting with floor division and converting back. Results are checked in
// order, field by field. A short directed set hits the calendar edges and
// every kind of bad field, then constrained random beats follow, mostly
// well-formed dates with some corrupted ones. The sender runs in bursts, the
// receiver stalls on a rotating pattern and once holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------

module tb_utc_datetime_normalizer_unit;

	typedef struct {
		utcdn_pkg::year_t  year;
		utcdn_pkg::field_t month;
		utcdn_pkg::field_t day;
		utcdn_pkg::field_t hour;
		utcdn_pkg::field_t minute;
		utcdn_pkg::field_t second;
		utcdn_pkg::zone_t  zone;
	} local_dt_t;

	typedef struct {
		logic                 dv;
		utcdn_pkg::utc_year_t year;
		logic [3:0]           month;
		logic [4:0]           day;
		logic [4:0]           hour;
		logic [5:0]           minute;
		logic [5:0]           second;
	} utc_dt_t;

	class utc_tracker;
		utc_dt_t expected_utc[$];
		int      mismatches = 0;
		int      taken = 0;

		function longint floor_quot(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0)
				q--;
			return q;
		endfunction

		function longint month_len(longint y, longint m);
			bit leap;
			leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
			if (m == utcdn_pkg::MONTH_FEB)
				return leap ? 29 : 28;
			if (m == utcdn_pkg::MONTH_APR || m == utcdn_pkg::MONTH_JUN ||
			    m == utcdn_pkg::MONTH_SEP || m == utcdn_pkg::MONTH_NOV)
				return 30;
			return 31;
		endfunction

		function utc_dt_t utc_of_local(local_dt_t t);
			utc_dt_t r;
			longint y, mo, d, h, mi, s, z;
			longint era, yoe, doy, doe, mp, total, days, secs, shifted;
			r = '{default: 0};
			y = t.year;
			mo = t.month;
			d = t.day;
			h = t.hour;
			mi = t.minute;
			s = t.second;
			z = t.zone;
			if (mo < 1 || mo > 12 || d < 1 || d > month_len(y, mo) || h > 23 || mi > 59 || s > 59)
				return r;
			// day count from 1970-01-01, March-based year
			if (mo <= 2)
				y = y - 1;
			era = floor_quot(y, 400);
			yoe = y - era * 400;
			mp = (mo > 2) ? mo - 3 : mo + 9;
			doy = (153 * mp + 2) / 5 + d - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			total = (era * 146097 + doe - 719468) * 86400 + h * 3600 + mi * 60 + s - z * 60;
			days = floor_quot(total, 86400);
			secs = total - days * 86400;
			// back to a civil date
			shifted = days + 719468;
			era = floor_quot(shifted, 146097);
			doe = shifted - era * 146097;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			d = doy - (153 * mp + 2) / 5 + 1;
			mo = (mp < 10) ? mp + 3 : mp - 9;
			y = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
			r.dv = 1'b1;
			r.year = utcdn_pkg::utc_year_t'(y);
			r.month = mo[3:0];
			r.day = d[4:0];
			r.hour = 5'(secs / 3600);
			r.minute = 6'((secs % 3600) / 60);
			r.second = 6'(secs % 60);
			return r;
		endfunction

		function void note_local(local_dt_t t);
			expected_utc.push_back(utc_of_local(t));
			taken++;
		endfunction

		function void compare(string name, longint e, longint a);
			if (e != a) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			end
		endfunction

		function void check_utc(utc_dt_t got);
			utc_dt_t e;
			if (expected_utc.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing pending, actual valid=%0d year=%0d",
					$time, got.dv, $signed(got.year));
				return;
			end
			e = expected_utc.pop_front();
			compare("date_valid", e.dv, got.dv);
			compare("utc_year", $signed(e.year), $signed(got.year));
			compare("utc_month", e.month, got.month);
			compare("utc_day", e.day, got.day);
			compare("utc_hour", e.hour, got.hour);
			compare("utc_minute", e.minute, got.minute);
			compare("utc_second", e.second, got.second);
		endfunction

		function int pending();
			return expected_utc.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	utcdn_in_if  req();
	utcdn_out_if rsp();

	utc_tracker tracker = new();

	int burst_left = 0;

	utc_datetime_normalizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	// Note accepted inputs first so a same-edge result still finds its entry.
	always @(posedge clk) begin : beat_monitor
		local_dt_t li;
		utc_dt_t   ro;
		if (arst_n && req.valid && req.ready) begin
			li.year = req.local_year;
			li.month = req.local_month;
			li.day = req.local_day;
			li.hour = req.local_hour;
			li.minute = req.local_minute;
			li.second = req.local_second;
			li.zone = req.zone_minutes;
			tracker.note_local(li);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			ro.dv = rsp.date_valid;
			ro.year = rsp.utc_year;
			ro.month = rsp.utc_month;
			ro.day = rsp.utc_day;
			ro.hour = rsp.utc_hour;
			ro.minute = rsp.utc_minute;
			ro.second = rsp.utc_second;
			tracker.check_utc(ro);
		end
	end

	// Receiver: rotate through always-ready, coin-flip, mostly-stalled and
	// periodic stretches; hold off once for a long run to fill the block.
	initial begin : receiver
		int  cyc;
		bit  held;
		int  mode;
		cyc = 0;
		held = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && tracker.taken >= 500) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				mode = (cyc / 97) % 4;
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					2: rsp.ready <= ($urandom_range(0, 3) == 0);
					default: rsp.ready <= (cyc % 5 != 0);
				endcase
			end
		end
	end

	function automatic local_dt_t mk(int y, int mo, int d, int h, int mi, int s, int z);
		local_dt_t t;
		t.year = utcdn_pkg::year_t'(y);
		t.month = utcdn_pkg::field_t'(mo);
		t.day = utcdn_pkg::field_t'(d);
		t.hour = utcdn_pkg::field_t'(h);
		t.minute = utcdn_pkg::field_t'(mi);
		t.second = utcdn_pkg::field_t'(s);
		t.zone = utcdn_pkg::zone_t'(z);
		return t;
	endfunction

	function automatic local_dt_t random_local();
		local_dt_t t;
		int        sel;
		int        len;
		sel = $urandom_range(0, 9);
		if (sel <= 5)
			t.year = utcdn_pkg::year_t'($urandom_range(0, 9999));
		else if (sel <= 7)
			t.year = utcdn_pkg::year_t'($urandom_range(0, 16383));
		else if (sel == 8)
			t.year = utcdn_pkg::year_t'($urandom_range(0, 2));
		else
			t.year = utcdn_pkg::year_t'($urandom_range(16381, 16383));
		t.month = utcdn_pkg::field_t'($urandom_range(1, 12));
		len = int'(tracker.month_len(t.year, t.month));
		t.day = ($urandom_range(0, 3) == 0) ? utcdn_pkg::field_t'(len) :
		        utcdn_pkg::field_t'($urandom_range(1, len));
		t.hour = utcdn_pkg::field_t'($urandom_range(0, 23));
		t.minute = utcdn_pkg::field_t'($urandom_range(0, 59));
		t.second = utcdn_pkg::field_t'($urandom_range(0, 59));
		if ($urandom_range(0, 9) < 7)
			t.zone = utcdn_pkg::zone_t'($urandom_range(0, 2878) - 1439);
		else
			t.zone = utcdn_pkg::zone_t'($urandom_range(0, 4095));
		// corrupt about a quarter of the beats
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 7))
				0: t.month = utcdn_pkg::field_t'($urandom_range(0, 127));
				1: t.day = utcdn_pkg::field_t'($urandom_range(0, 127));
				2: t.hour = utcdn_pkg::field_t'($urandom_range(0, 127));
				3: t.minute = utcdn_pkg::field_t'($urandom_range(0, 127));
				4: t.second = utcdn_pkg::field_t'($urandom_range(0, 127));
				5: t.day = utcdn_pkg::field_t'(len + 1);
				6: t.month = ($urandom_range(0, 1) == 0) ? utcdn_pkg::field_t'(0) :
				             utcdn_pkg::field_t'(13);
				default: begin
					t.year = utcdn_pkg::year_t'($urandom_range(0, 16383));
					t.month = utcdn_pkg::field_t'($urandom_range(0, 127));
					t.day = utcdn_pkg::field_t'($urandom_range(0, 127));
					t.hour = utcdn_pkg::field_t'($urandom_range(0, 127));
					t.minute = utcdn_pkg::field_t'($urandom_range(0, 127));
					t.second = utcdn_pkg::field_t'($urandom_range(0, 127));
					t.zone = utcdn_pkg::zone_t'($urandom_range(0, 4095));
				end
			endcase
		end
		return t;
	endfunction

	task automatic offer(local_dt_t t);
		req.valid <= 1'b1;
		req.local_year <= t.year;
		req.local_month <= t.month;
		req.local_day <= t.day;
		req.local_hour <= t.hour;
		req.local_minute <= t.minute;
		req.local_second <= t.second;
		req.zone_minutes <= t.zone;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	// Bursts of back-to-back beats separated by random idle gaps.
	task automatic paced_offer(local_dt_t t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		offer(t);
	endtask

	initial begin : stimulus
		local_dt_t directed[$];
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.local_year <= '0;
		req.local_month <= '0;
		req.local_day <= '0;
		req.local_hour <= '0;
		req.local_minute <= '0;
		req.local_second <= '0;
		req.zone_minutes <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(mk(1970, 1, 1, 0, 0, 0, 0));
		directed.push_back(mk(0, 1, 1, 0, 0, 0, 1439));        // back into year -1
		directed.push_back(mk(0, 2, 29, 12, 0, 0, 0));         // year zero is leap
		directed.push_back(mk(16383, 12, 31, 23, 59, 59, -2048)); // year wraps
		directed.push_back(mk(9999, 12, 31, 23, 59, 59, -1439));
		directed.push_back(mk(2000, 2, 29, 23, 30, 0, -60));
		directed.push_back(mk(1900, 2, 29, 0, 0, 0, 0));       // century non-leap
		directed.push_back(mk(2024, 2, 29, 0, 10, 0, 120));
		directed.push_back(mk(2023, 2, 29, 0, 0, 0, 0));
		directed.push_back(mk(2024, 4, 31, 0, 0, 0, 0));
		directed.push_back(mk(2024, 0, 1, 0, 0, 0, 0));
		directed.push_back(mk(2024, 13, 1, 0, 0, 0, 0));
		directed.push_back(mk(2024, 127, 1, 0, 0, 0, 0));
		directed.push_back(mk(2024, 5, 0, 0, 0, 0, 0));
		directed.push_back(mk(2024, 5, 127, 0, 0, 0, 0));
		directed.push_back(mk(2024, 5, 1, 24, 0, 0, 0));
		directed.push_back(mk(2024, 5, 1, 127, 0, 0, 0));
		directed.push_back(mk(2024, 5, 1, 0, 60, 0, 0));
		directed.push_back(mk(2024, 5, 1, 0, 127, 0, 0));
		directed.push_back(mk(2024, 5, 1, 0, 0, 60, 0));
		directed.push_back(mk(2024, 5, 1, 0, 0, 127, 0));
		directed.push_back(mk(2024, 3, 1, 0, 0, 0, 2047));     // offset beyond a day
		directed.push_back(mk(2023, 12, 31, 22, 0, 0, -2048));
		directed.push_back(mk(2100, 3, 1, 0, 0, 0, 1));
		directed.push_back(mk(16383, 6, 15, 12, 0, 0, 0));
		foreach (directed[i])
			paced_offer(directed[i]);

		repeat (1450)
			paced_offer(random_local());
		req.valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/utcdn_pkg.sv
rtl/utcdn_in_if.sv
rtl/utcdn_out_if.sv
rtl/utc_datetime_normalizer_unit.sv
rtl/utcdn_checker.sv
tb/tb_utc_datetime_normalizer_unit.sv
